// ----- rtl/msiu_pkg.sv -----
// ----------------------------------------------------------------------------
// msiu_pkg
// shared types, function codes and helpers of the special integer unit
// ----------------------------------------------------------------------------
package msiu_pkg;

   localparam int unsigned STEPS  = 64;
   localparam int unsigned CNT_W  = $clog2(STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   localparam logic [2:0] EXC_NONE     = 3'd0;
   localparam logic [2:0] EXC_OVERFLOW = 3'd1;
   localparam logic [2:0] EXC_TRAP     = 3'd2;
   localparam logic [2:0] EXC_RESERVED = 3'd3;
   localparam logic [2:0] EXC_SYSCALL  = 3'd4;
   localparam logic [2:0] EXC_BREAK    = 3'd5;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0c;
   localparam logic [5:0] FN_BREAK   = 6'h0d;
   localparam logic [5:0] FN_SYNC    = 6'h0f;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_DSLLV   = 6'h14;
   localparam logic [5:0] FN_DSRLV   = 6'h16;
   localparam logic [5:0] FN_DSRAV   = 6'h17;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1a;
   localparam logic [5:0] FN_DIVU    = 6'h1b;
   localparam logic [5:0] FN_DMULT   = 6'h1c;
   localparam logic [5:0] FN_DMULTU  = 6'h1d;
   localparam logic [5:0] FN_DDIV    = 6'h1e;
   localparam logic [5:0] FN_DDIVU   = 6'h1f;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2a;
   localparam logic [5:0] FN_SLTU    = 6'h2b;
   localparam logic [5:0] FN_DADD    = 6'h2c;
   localparam logic [5:0] FN_DADDU   = 6'h2d;
   localparam logic [5:0] FN_DSUB    = 6'h2e;
   localparam logic [5:0] FN_DSUBU   = 6'h2f;
   localparam logic [5:0] FN_TGE     = 6'h30;
   localparam logic [5:0] FN_TGEU    = 6'h31;
   localparam logic [5:0] FN_TLT     = 6'h32;
   localparam logic [5:0] FN_TLTU    = 6'h33;
   localparam logic [5:0] FN_TEQ     = 6'h34;
   localparam logic [5:0] FN_TNE     = 6'h36;
   localparam logic [5:0] FN_DSLL    = 6'h38;
   localparam logic [5:0] FN_DSRL    = 6'h3a;
   localparam logic [5:0] FN_DSRA    = 6'h3b;
   localparam logic [5:0] FN_DSLL32  = 6'h3c;
   localparam logic [5:0] FN_DSRL32  = 6'h3e;
   localparam logic [5:0] FN_DSRA32  = 6'h3f;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_MUL,
      S_DIV,
      S_DONE
   } msiu_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step_mul;
      logic step_div;
      logic complete;
   } msiu_cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
   } msiu_stat_type;

   function automatic logic [63:0] sext32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic logic is_wide_fn(input logic [5:0] fn);
      return fn == FN_DSLLV || fn == FN_DSRLV || fn == FN_DSRAV ||
             fn == FN_DMULT || fn == FN_DMULTU || fn == FN_DDIV || fn == FN_DDIVU ||
             fn == FN_DADD || fn == FN_DADDU || fn == FN_DSUB || fn == FN_DSUBU ||
             fn == FN_DSLL || fn == FN_DSRL || fn == FN_DSRA ||
             fn == FN_DSLL32 || fn == FN_DSRL32 || fn == FN_DSRA32;
   endfunction

endpackage

// ----- rtl/msiu_req_if.sv -----
// ----------------------------------------------------------------------------
// msiu_req_if
// request channel: instruction word, operands and delay-slot address
// ----------------------------------------------------------------------------
interface msiu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   logic [63:0] operand_a;
   logic [63:0] operand_b;
   logic [63:0] following_address;

   modport source (output valid, instruction_word, operand_a, operand_b,
                   following_address, input ready);
   modport sink (input valid, instruction_word, operand_a, operand_b,
                 following_address, output ready);
endinterface

// ----- rtl/msiu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// msiu_rsp_if
// result channel: register write, jump and exception code
// ----------------------------------------------------------------------------
interface msiu_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [4:0]  write_register;
   logic [63:0] write_value;
   logic        jump_taken;
   logic [63:0] jump_target;
   logic [2:0]  exception_code;

   modport source (output valid, write_enable, write_register, write_value,
                   jump_taken, jump_target, exception_code, input ready);
   modport sink (input valid, write_enable, write_register, write_value,
                 jump_taken, jump_target, exception_code, output ready);
endinterface

// ----- rtl/mips64_special_integer_unit.sv -----
// ----------------------------------------------------------------------------
// mips64_special_integer_unit
// executes one MIPS III SPECIAL instruction per request, keeps hi and lo
// ----------------------------------------------------------------------------
// usage
//   req_port: instruction word, rs and rt values and delay-slot address;
//     a request is taken when valid and ready are both high
//   rsp_port: register write, jump and exception code, one per request
//   csr_write_enable / csr_write_data: wide_enable, to be written by the
//     user only when idle, unchecked by the block; 0 turns the doubleword
//     instructions into reserved instructions
// sequence
//   alu, shift, trap, jump and hi/lo moves: setup, then complete
//   multiply and divide: setup, the 64-step shift-add multiply or
//     restoring divide loop, then complete
//   the next request is taken in the cycle after the result is loaded
// reset
//   synchronous, active high: hi and lo clear, wide_enable goes to 1
// stall
//   a finished result holds in the output register while rsp_port.ready
//   is low; a second result waits in its last state until the slot frees
// ----------------------------------------------------------------------------
module mips64_special_integer_unit (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   msiu_req_if.sink  req_port,
   msiu_rsp_if.source rsp_port
);
   import msiu_pkg::*;

   msiu_cmd_type  cmd;   // sequencer to datapath
   msiu_stat_type stat;  // decoded op class back to sequencer

   msiu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // operands, hi/lo, iterative mul/div and the result register
   msiu_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .stat              (stat),
      .instruction_word  (req_port.instruction_word),
      .operand_a         (req_port.operand_a),
      .operand_b         (req_port.operand_b),
      .following_address (req_port.following_address),
      .write_enable      (rsp_port.write_enable),
      .write_register    (rsp_port.write_register),
      .write_value       (rsp_port.write_value),
      .jump_taken        (rsp_port.jump_taken),
      .jump_target       (rsp_port.jump_target),
      .exception_code    (rsp_port.exception_code)
   );

endmodule

// ----- rtl/msiu_datapath.sv -----
// ----------------------------------------------------------------------------
// msiu_datapath
// operand latches, hi/lo, shared shift-add / restoring divide loop, alu
// ----------------------------------------------------------------------------
module msiu_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  msiu_pkg::msiu_cmd_type  cmd,
   output msiu_pkg::msiu_stat_type stat,
   input  logic [31:0]          instruction_word,
   input  logic [63:0]          operand_a,
   input  logic [63:0]          operand_b,
   input  logic [63:0]          following_address,
   output logic                 write_enable,
   output logic [4:0]           write_register,
   output logic [63:0]          write_value,
   output logic                 jump_taken,
   output logic [63:0]          jump_target,
   output logic [2:0]           exception_code
);
   import msiu_pkg::*;

   logic [15:0] iw_ff;
   logic [63:0] a_ff, b_ff, nxt_ff;
   logic        wide_ff;
   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [63:0] ph_ff, ph_in, pl_ff, pl_in, mcand_ff, mcand_in, corr_ff, corr_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic        we_ff, jmp_ff;
   logic [4:0]  rd_ff;
   logic [63:0] val_ff, tgt_ff;
   logic [2:0]  exc_ff;

   logic [5:0]  fn;
   logic [4:0]  sa, rd;
   logic        reserved;

   assign fn = iw_ff[5:0];
   assign sa = iw_ff[10:6];
   assign rd = iw_ff[15:11];
   assign reserved = is_wide_fn(fn) && !wide_ff;
   assign stat.is_mul = !reserved && (fn == FN_MULT || fn == FN_MULTU ||
                                      fn == FN_DMULT || fn == FN_DMULTU);
   assign stat.is_div = !reserved && (fn == FN_DIV || fn == FN_DIVU ||
                                      fn == FN_DDIV || fn == FN_DDIVU);

   // loop setup and steps
   logic [64:0] mul_sum;
   logic [65:0] div_trial;
   logic [63:0] n_sel, d_sel, b35;
   logic        div_signed;

   always_comb begin
      ph_in    = ph_ff;
      pl_in    = pl_ff;
      mcand_in = mcand_ff;
      corr_in  = corr_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      b35      = {{29{b_ff[34]}}, b_ff[34:0]};
      div_signed = fn == FN_DIV || fn == FN_DDIV;
      n_sel = (fn == FN_DIV) ? sext32(a_ff) :
              (fn == FN_DIVU) ? {32'b0, a_ff[31:0]} : a_ff;
      d_sel = (fn == FN_DIVU) ? {32'b0, b_ff[31:0]} : b_ff;
      mul_sum   = {1'b0, ph_ff} + (pl_ff[0] ? {1'b0, mcand_ff} : 65'b0);
      div_trial = {1'b0, ph_ff, pl_ff[63]} - {2'b0, mcand_ff};
      if (cmd.setup && stat.is_mul) begin
         ph_in = '0;
         priority case (fn)
            FN_MULT: begin
               pl_in = b35; mcand_in = a_ff;
            end
            FN_MULTU: begin
               pl_in = {32'b0, b_ff[31:0]}; mcand_in = {32'b0, a_ff[31:0]};
            end
            default: begin
               pl_in = b_ff; mcand_in = a_ff;
            end
         endcase
         corr_in = (fn == FN_DMULT) ? ((a_ff[63] ? b_ff : 64'b0) +
                                       (b_ff[63] ? a_ff : 64'b0)) : 64'b0;
      end else if (cmd.setup && stat.is_div) begin
         ph_in    = '0;
         pl_in    = (div_signed && n_sel[63]) ? (64'b0 - n_sel) : n_sel;
         mcand_in = (div_signed && d_sel[63]) ? (64'b0 - d_sel) : d_sel;
         neg_q_in = div_signed && (n_sel[63] ^ d_sel[63]);
         neg_r_in = div_signed && n_sel[63];
      end else if (cmd.step_mul) begin
         {ph_in, pl_in} = {mul_sum, pl_ff[63:1]};
      end else if (cmd.step_div) begin
         if (!div_trial[65]) begin
            ph_in = div_trial[63:0];
         end else begin
            ph_in = {ph_ff[62:0], pl_ff[63]};
         end
         pl_in = {pl_ff[62:0], !div_trial[65]};
      end
   end

   // alu and completion
   logic [63:0] sum, dif, q_fix, r_fix, t64, val;
   logic [31:0] t32;
   logic        lt_s, lt_u, we, jmp;
   logic [2:0]  exc;

   always_comb begin
      sum   = a_ff + b_ff;
      dif   = a_ff - b_ff;
      lt_s  = $signed(a_ff) < $signed(b_ff);
      lt_u  = a_ff < b_ff;
      q_fix = neg_q_ff ? (64'b0 - pl_ff) : pl_ff;
      r_fix = neg_r_ff ? (64'b0 - ph_ff) : ph_ff;
      t32   = '0;
      t64   = '0;
      we    = 1'b0;
      jmp   = 1'b0;
      val   = '0;
      exc   = EXC_NONE;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (reserved) begin
         exc = EXC_RESERVED;
      end else begin
         unique case (fn)
            FN_SLL: begin
               t32 = b_ff[31:0] << sa; we = 1'b1; val = {{32{t32[31]}}, t32};
            end
            FN_SRL: begin
               t32 = b_ff[31:0] >> sa; we = 1'b1; val = {{32{t32[31]}}, t32};
            end
            FN_SRA: begin
               t64 = $signed(b_ff) >>> sa; we = 1'b1; val = sext32(t64);
            end
            FN_SLLV: begin
               t32 = b_ff[31:0] << a_ff[4:0]; we = 1'b1; val = {{32{t32[31]}}, t32};
            end
            FN_SRLV: begin
               t32 = b_ff[31:0] >> a_ff[4:0]; we = 1'b1; val = {{32{t32[31]}}, t32};
            end
            FN_SRAV: begin
               t64 = $signed(b_ff) >>> a_ff[4:0]; we = 1'b1; val = sext32(t64);
            end
            FN_JR:      jmp = 1'b1;
            FN_JALR: begin
               jmp = 1'b1; we = 1'b1; val = nxt_ff + 64'd4;
            end
            FN_SYSCALL: exc = EXC_SYSCALL;
            FN_BREAK:   exc = EXC_BREAK;
            FN_SYNC: begin
            end
            FN_MFHI: begin
               we = 1'b1; val = hi_ff;
            end
            FN_MTHI:    hi_in = a_ff;
            FN_MFLO: begin
               we = 1'b1; val = lo_ff;
            end
            FN_MTLO:    lo_in = a_ff;
            FN_DSLLV: begin
               we = 1'b1; val = b_ff << a_ff[5:0];
            end
            FN_DSRLV: begin
               we = 1'b1; val = b_ff >> a_ff[5:0];
            end
            FN_DSRAV: begin
               t64 = $signed(b_ff) >>> a_ff[5:0]; we = 1'b1; val = t64;
            end
            FN_MULT, FN_MULTU: begin
               lo_in = sext32(pl_ff);
               hi_in = {{32{pl_ff[63]}}, pl_ff[63:32]};
            end
            FN_DMULT, FN_DMULTU: begin
               lo_in = pl_ff;
               hi_in = ph_ff - corr_ff;
            end
            FN_DIV, FN_DIVU: begin
               lo_in = sext32(q_fix);
               hi_in = sext32(r_fix);
            end
            FN_DDIV, FN_DDIVU: begin
               lo_in = q_fix;
               hi_in = r_fix;
            end
            FN_ADD, FN_ADDU: begin
               if (fn == FN_ADD && (~(a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ sum[31]))) begin
                  exc = EXC_OVERFLOW;
               end else begin
                  we = 1'b1; val = sext32(sum);
               end
            end
            FN_SUB, FN_SUBU: begin
               if (fn == FN_SUB && ((a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ dif[31]))) begin
                  exc = EXC_OVERFLOW;
               end else begin
                  we = 1'b1; val = sext32(dif);
               end
            end
            FN_AND: begin
               we = 1'b1; val = a_ff & b_ff;
            end
            FN_OR: begin
               we = 1'b1; val = a_ff | b_ff;
            end
            FN_XOR: begin
               we = 1'b1; val = a_ff ^ b_ff;
            end
            FN_NOR: begin
               we = 1'b1; val = ~(a_ff | b_ff);
            end
            FN_SLT: begin
               we = 1'b1; val = {63'b0, lt_s};
            end
            FN_SLTU: begin
               we = 1'b1; val = {63'b0, lt_u};
            end
            FN_DADD, FN_DADDU: begin
               if (fn == FN_DADD && (~(a_ff[63] ^ b_ff[63]) & (a_ff[63] ^ sum[63]))) begin
                  exc = EXC_OVERFLOW;
               end else begin
                  we = 1'b1; val = sum;
               end
            end
            FN_DSUB, FN_DSUBU: begin
               if (fn == FN_DSUB && ((a_ff[63] ^ b_ff[63]) & (a_ff[63] ^ dif[63]))) begin
                  exc = EXC_OVERFLOW;
               end else begin
                  we = 1'b1; val = dif;
               end
            end
            FN_TGE:  if (!lt_s) exc = EXC_TRAP;
            FN_TGEU: if (!lt_u) exc = EXC_TRAP;
            FN_TLT:  if (lt_s) exc = EXC_TRAP;
            FN_TLTU: if (lt_u) exc = EXC_TRAP;
            FN_TEQ:  if (a_ff == b_ff) exc = EXC_TRAP;
            FN_TNE:  if (a_ff != b_ff) exc = EXC_TRAP;
            FN_DSLL: begin
               we = 1'b1; val = b_ff << sa;
            end
            FN_DSRL: begin
               we = 1'b1; val = b_ff >> sa;
            end
            FN_DSRA: begin
               t64 = $signed(b_ff) >>> sa; we = 1'b1; val = t64;
            end
            FN_DSLL32: begin
               we = 1'b1; val = b_ff << {1'b1, sa};
            end
            FN_DSRL32: begin
               we = 1'b1; val = b_ff >> {1'b1, sa};
            end
            FN_DSRA32: begin
               t64 = $signed(b_ff) >>> {1'b1, sa}; we = 1'b1; val = t64;
            end
            default: exc = EXC_RESERVED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b1;
         hi_ff   <= '0;
         lo_ff   <= '0;
      end else begin
         if (csr_write_enable) wide_ff <= csr_write_data;
         if (cmd.complete) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         iw_ff  <= instruction_word[15:0];
         a_ff   <= operand_a;
         b_ff   <= operand_b;
         nxt_ff <= following_address;
      end
      ph_ff    <= ph_in;
      pl_ff    <= pl_in;
      mcand_ff <= mcand_in;
      corr_ff  <= corr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      if (cmd.complete) begin
         we_ff  <= we;
         rd_ff  <= we ? rd : 5'd0;
         val_ff <= we ? val : 64'd0;
         jmp_ff <= jmp;
         tgt_ff <= jmp ? a_ff : 64'd0;
         exc_ff <= exc;
      end
   end

   assign write_enable   = we_ff;
   assign write_register = rd_ff;
   assign write_value    = val_ff;
   assign jump_taken     = jmp_ff;
   assign jump_target    = tgt_ff;
   assign exception_code = exc_ff;

endmodule

// ----- rtl/msiu_controller.sv -----
// ----------------------------------------------------------------------------
// msiu_controller
// sequencer: accept, setup, 64-step loop, completion into the output register
// ----------------------------------------------------------------------------
module msiu_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  msiu_pkg::msiu_stat_type stat,
   output msiu_pkg::msiu_cmd_type  cmd
);
   import msiu_pkg::*;

   msiu_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            priority if (stat.is_mul) state_in = S_MUL;
            else if (stat.is_div)     state_in = S_DIV;
            else                      state_in = S_DONE;
         end
         S_MUL, S_DIV: begin
            cmd.step_mul = state_ff == S_MUL;
            cmd.step_div = state_ff == S_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.complete = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.setup, cmd.step_mul, cmd.step_div, cmd.complete}))
      else $error("more than one datapath command");

   a_complete_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.complete |-> slot_free)
      else $error("result overwrites a waiting result");

   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_SETUP)
      else $error("accepted request not set up");

   a_loop_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL || state_ff == S_DIV) && cnt_ff == CNT_LAST) |=>
      state_ff == S_DONE)
      else $error("loop did not end after last step");

endmodule
